// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_ADDR_W      = 4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_ZERO_LEN  = 3'd2;
    localparam logic [2:0] ST_WRONG_CMD = 3'd3;
    localparam logic [2:0] ST_BAD_SUM   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;
    localparam logic [2:0] ST_TOO_LONG  = 3'd6;

    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_EXP_CMD    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [7:0]  START_BYTE_RST = 8'd22;
    localparam logic [7:0]  EXP_CMD_RST    = 8'd0;
    localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic [5:0] payload_length;
        logic       last;
    } t_out_resp;

endpackage

// File: rtl/core/sensor_frame_receiver.sv
// Byte-serial frame receiver: start, length, command, payload, checksum.
// Request channel (i_valid/o_ready/i_req): one received byte or one tick
// per request. Response channel (o_valid/i_ready/o_resp): one response per
// error, or one per payload byte of a good frame (last marks the final one).
// A good frame with an empty payload gives a single response of length zero.
// The front parser takes one request per cycle while it has queue room; it
// holds off payload and checksum bytes while the response engine still
// drains an earlier frame, since both share the payload store.
// An error response goes through the queue, then the output register; a good
// frame's checksum byte queues it, then each payload byte in turn takes a store
// read, then an output register load.
// Reset clears the parser (hunting for a start byte), the tick count, the
// queue and the output valid flag and loads the register defaults.
// A stalled response holds in the output register; the queue of two entries
// keeps the parser running until it fills.
// Registers over APB at 0x0 start byte, 0x4 command, 0x8 timeout ticks.
`include "assert_macros.svh"

module sensor_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_req               i_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_resp             o_resp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW    = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CMD_W = 3 + CW;

    logic [7:0]  r_start_byte;
    logic [7:0]  r_exp_cmd;
    logic [15:0] r_timeout;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CMD_W-1:0] q_in;
    logic [CMD_W-1:0] q_out;
    logic [2:0]       cmd_status;
    logic [CW-1:0]    cmd_count;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             back_busy;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign q_in   = {cmd_status, cmd_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_exp_cmd    <= EXP_CMD_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_START_BYTE: r_start_byte <= pwdata[7:0];
                REG_EXP_CMD:    r_exp_cmd    <= pwdata[7:0];
                REG_TIMEOUT:    r_timeout    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START_BYTE: prdata = {24'd0, r_start_byte};
            REG_EXP_CMD:    prdata = {24'd0, r_exp_cmd};
            REG_TIMEOUT:    prdata = {16'd0, r_timeout};
            default:        prdata = '0;
        endcase
    end

    sfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CW          (CW),
        .AW          (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req        (i_req),
        .i_start_byte (r_start_byte),
        .i_exp_cmd    (r_exp_cmd),
        .i_timeout    (r_timeout),
        .i_q_full     (q_full),
        .i_store_busy (!q_empty || back_busy),
        .o_push       (q_push),
        .o_cmd_status (cmd_status),
        .o_cmd_count  (cmd_count),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    sfr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CW          (CW),
        .AW          (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!q_empty),
        .i_cmd_status (q_out[CMD_W-1:CW]),
        .i_cmd_count  (q_out[CW-1:0]),
        .o_cmd_pop    (q_pop),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .o_busy       (back_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_resp       (o_resp)
    );

    `ASSERT_NEVER(a_store_write_busy, i_clk, i_rst_n, wr_en && (back_busy || !q_empty))
    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, q_push && q_full)
    `ASSERT_IMPLY(a_pop_has_entry, i_clk, i_rst_n, q_pop, !q_empty)

endmodule

// File: rtl/core/sfr_queue.sv
module sfr_queue
    import sfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int CW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in_req       i_req,
    input  logic [7:0]    i_start_byte,
    input  logic [7:0]    i_exp_cmd,
    input  logic [15:0]   i_timeout,
    input  logic          i_q_full,
    input  logic          i_store_busy,
    output logic          o_push,
    output logic [2:0]    o_cmd_status,
    output logic [CW-1:0] o_cmd_count,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data
);

    localparam int PW = $clog2(MAX_PAYLOAD + 4);
    localparam int LW = $clog2(MAX_PAYLOAD + 2);
    localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD + 1);

    logic [PW-1:0] r_pos;
    logic [LW-1:0] r_len;
    logic [7:0]    r_sum;
    logic [15:0]   r_cnt;

    logic [PW-1:0] n_pos;
    logic [LW-1:0] n_len;
    logic [7:0]    n_sum;
    logic [15:0]   n_cnt;

    logic          accept;
    logic          in_payload;
    logic [16:0]   cnt_inc;
    logic [7:0]    b;
    logic [PW-1:0] slot;

    assign b          = i_req.rx_byte;
    assign accept     = i_valid && o_ready;
    assign o_ready    = !i_q_full && !((r_pos >= PW'(3)) && i_store_busy);
    assign cnt_inc    = {1'b0, r_cnt} + 17'd1;
    assign in_payload = ((PW + 1)'(r_pos) < ((PW + 1)'(r_len) + (PW + 1)'(2)));
    assign slot       = r_pos - PW'(3);
    assign o_wr_addr  = slot[AW-1:0];
    assign o_wr_data  = b;

    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        o_push       = 1'b0;
        o_cmd_status = ST_OK;
        o_cmd_count  = '0;
        o_wr_en      = 1'b0;
        if (accept) begin
            if (i_req.req_type == REQ_TICK) begin
                if (cnt_inc >= {1'b0, i_timeout}) begin
                    o_push       = 1'b1;
                    o_cmd_status = ST_TIMEOUT;
                end else begin
                    n_cnt = cnt_inc[15:0];
                end
            end else if (r_pos == PW'(0)) begin
                if (b != i_start_byte) begin
                    o_push       = 1'b1;
                    o_cmd_status = ST_BAD_START;
                end else begin
                    n_sum = b;
                    n_pos = PW'(1);
                end
            end else if (r_pos == PW'(1)) begin
                if (b == 8'd0) begin
                    o_push       = 1'b1;
                    o_cmd_status = ST_ZERO_LEN;
                end else if ({1'b0, b} > LEN_LIMIT) begin
                    o_push       = 1'b1;
                    o_cmd_status = ST_TOO_LONG;
                end else begin
                    n_len = LW'(b);
                    n_sum = r_sum + b;
                    n_pos = PW'(2);
                end
            end else if (r_pos == PW'(2)) begin
                if (b != i_exp_cmd) begin
                    o_push       = 1'b1;
                    o_cmd_status = ST_WRONG_CMD;
                end else begin
                    n_sum = r_sum + b;
                    n_pos = PW'(3);
                end
            end else if (in_payload) begin
                o_wr_en = 1'b1;
                n_sum   = r_sum + b;
                n_pos   = r_pos + 1'b1;
            end else begin
                o_push = 1'b1;
                if ((8'd0 - r_sum) != b) begin
                    o_cmd_status = ST_BAD_SUM;
                end else begin
                    o_cmd_count = CW'(r_len - 1'b1);
                end
            end
            if (o_push) begin
                n_pos = '0;
                n_len = '0;
                n_sum = '0;
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/core/sfr_back.sv
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int CW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  logic [2:0]    i_cmd_status,
    input  logic [CW-1:0] i_cmd_count,
    output logic          o_cmd_pop,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic          o_busy,
    output logic          o_valid,
    input  logic          i_ready,
    output t_out_resp     o_resp
);

    localparam int XW = (CW > 6) ? CW : 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state        r_state;
    logic          r_out_valid;
    t_out_resp     r_out;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic [7:0]    r_rd;
    logic [7:0]    r_store [MAX_PAYLOAD];

    logic          out_free;
    logic          out_load;
    logic          is_last;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] n_x;

    assign out_free  = !r_out_valid || i_ready;
    assign o_cmd_pop = i_cmd_valid && (r_state == S_IDLE)
                       && ((i_cmd_count != '0) || out_free);
    assign out_load  = ((r_state == S_IDLE) && o_cmd_pop && (i_cmd_count == '0))
                       || ((r_state == S_SEND) && out_free);
    assign is_last   = (CW'(r_idx + 1'b1) == r_n);
    assign idx_x     = XW'(r_idx);
    assign n_x       = XW'(r_n);
    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_resp    = r_out;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_store[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd_count == '0) begin
                            r_out.status         <= i_cmd_status;
                            r_out.data_byte      <= '0;
                            r_out.byte_index     <= '0;
                            r_out.payload_length <= '0;
                            r_out.last           <= 1'b1;
                        end else begin
                            r_n     <= i_cmd_count;
                            r_idx   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        r_out.status         <= ST_OK;
                        r_out.data_byte      <= r_rd;
                        r_out.byte_index     <= idx_x[4:0];
                        r_out.payload_length <= n_x[5:0];
                        r_out.last           <= is_last;
                        r_idx                <= r_idx + 1'b1;
                        r_state              <= is_last ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: verif/tb_sensor_frame_receiver.sv
module tb_sensor_frame_receiver;
    import sfr_pkg::*;

    localparam int PAYLOAD_CAP   = MAX_PAYLOAD_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 320;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum {FL_NONE, FL_START, FL_ZERO, FL_LONG, FL_CMD, FL_SUM, FL_CUT} t_flaw;

    typedef struct packed {
        logic       kind;
        logic [7:0] val;
        logic       typed;
        logic [2:0] st;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_req               i_req;
    logic                  o_valid;
    logic                  i_ready;
    t_out_resp             o_resp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    sensor_frame_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_resp  (o_resp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  cfg_start;
    logic [7:0]  cfg_cmd;
    logic [15:0] cfg_timeout;

    int          rx_pos;
    logic [7:0]  rx_len;
    logic [7:0]  rx_sum;
    logic [7:0]  pay_store [PAYLOAD_CAP];
    int          tick_cnt;

    t_out_resp   want_resp [$];
    t_out_resp   fresh_resp [$];
    t_dir_row    directed_tab [DIRECTED_ROWS];

    int          sent_cnt = 0;
    int          n_errors = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_sensor_frame_receiver failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_resp resp(logic [2:0] st, logic [7:0] d, logic [4:0] idx,
                                       logic [5:0] len, logic last);
        t_out_resp o;
        o.status         = st;
        o.data_byte      = d;
        o.byte_index     = idx;
        o.payload_length = len;
        o.last           = last;
        return o;
    endfunction

    function automatic void back_to_hunt();
        rx_pos   = 0;
        rx_len   = 8'd0;
        rx_sum   = 8'd0;
        tick_cnt = 0;
    endfunction

    function automatic void flag_error(logic [2:0] st);
        back_to_hunt();
        fresh_resp.push_back(resp(st, 8'd0, 5'd0, 6'd0, 1'b1));
    endfunction

    function automatic void parse_request(t_in_req r);
        logic [7:0] b;
        logic [7:0] want_sum;
        int n;
        fresh_resp.delete();
        b = r.rx_byte;
        if (r.req_type == REQ_TICK) begin
            tick_cnt++;
            if (tick_cnt >= int'(cfg_timeout)) flag_error(ST_TIMEOUT);
            return;
        end
        if (rx_pos == 0) begin
            if (b != cfg_start) begin
                flag_error(ST_BAD_START);
            end else begin
                rx_sum = b;
                rx_pos = 1;
            end
        end else if (rx_pos == 1) begin
            if (b == 8'd0) begin
                flag_error(ST_ZERO_LEN);
            end else if (int'(b) > PAYLOAD_CAP + 1) begin
                flag_error(ST_TOO_LONG);
            end else begin
                rx_len = b;
                rx_sum = rx_sum + b;
                rx_pos = 2;
            end
        end else if (rx_pos == 2) begin
            if (b != cfg_cmd) begin
                flag_error(ST_WRONG_CMD);
            end else begin
                rx_sum = rx_sum + b;
                rx_pos = 3;
            end
        end else if (rx_pos < int'(rx_len) + 2) begin
            pay_store[rx_pos - 3] = b;
            rx_sum = rx_sum + b;
            rx_pos++;
        end else begin
            want_sum = 8'd0 - rx_sum;
            if (want_sum != b) begin
                flag_error(ST_BAD_SUM);
            end else begin
                n = int'(rx_len) - 1;
                back_to_hunt();
                if (n == 0) begin
                    fresh_resp.push_back(resp(ST_OK, 8'd0, 5'd0, 6'd0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        fresh_resp.push_back(resp(ST_OK, pay_store[i], 5'(i), 6'(n),
                                                  i == n - 1));
                    end
                end
            end
        end
    endfunction

    task automatic offer_req(input t_in_req r);
        int g;
        g = idle_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        sent_cnt++;
        parse_request(r);
    endtask

    task automatic send_req(input t_in_req r);
        offer_req(r);
        foreach (fresh_resp[j]) want_resp.push_back(fresh_resp[j]);
    endtask

    task automatic send_frame(input int plen, input t_flaw flaw);
        logic [7:0] fb [$];
        logic [7:0] acc;
        logic [7:0] nz;
        int keep;
        nz = 8'($urandom_range(1, 255));
        fb.push_back(flaw == FL_START ? cfg_start ^ nz : cfg_start);
        if (flaw != FL_START) begin
            case (flaw)
                FL_ZERO: fb.push_back(8'd0);
                FL_LONG: fb.push_back(8'($urandom_range(PAYLOAD_CAP + 2, 255)));
                default: fb.push_back(8'(plen + 1));
            endcase
            if (flaw != FL_ZERO && flaw != FL_LONG) begin
                fb.push_back(flaw == FL_CMD ? cfg_cmd ^ nz : cfg_cmd);
                if (flaw != FL_CMD) begin
                    repeat (plen) fb.push_back(8'($urandom));
                    acc = 8'd0;
                    foreach (fb[i]) acc = acc + fb[i];
                    fb.push_back(flaw == FL_SUM ? (8'd0 - acc) ^ nz : 8'd0 - acc);
                end
            end
        end
        if (flaw == FL_CUT) begin
            keep = $urandom_range(1, fb.size() - 1);
            while (fb.size() > keep) void'(fb.pop_back());
        end
        foreach (fb[i]) begin
            if ($urandom_range(0, 31) == 0) send_req({REQ_TICK, 8'($urandom)});
            send_req({REQ_BYTE, fb[i]});
        end
        // run out the clock on a broken frame
        if (flaw == FL_CUT && cfg_timeout <= 16'd40) begin
            while (rx_pos != 0) send_req({REQ_TICK, 8'($urandom)});
        end
    endtask

    function automatic int pick_plen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 6);
        if (r < 96) return $urandom_range(7, PAYLOAD_CAP - 1);
        return PAYLOAD_CAP;
    endfunction

    task automatic run_until(input int cnt);
        int r;
        t_in_req nz;
        while (sent_cnt < cnt) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                send_frame(pick_plen(), FL_NONE);
            end else if (r < 88) begin
                send_frame(pick_plen(), t_flaw'($urandom_range(1, 6)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    nz.req_type = 1'($urandom);
                    nz.rx_byte  = 8'($urandom);
                    send_req(nz);
                end
            end
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (want_resp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_BYTE: cfg_start   = val[7:0];
            REG_EXP_CMD:    cfg_cmd     = val[7:0];
            REG_TIMEOUT:    cfg_timeout = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] s, input logic [7:0] c,
                                input logic [15:0] t);
        apb_write(REG_START_BYTE, {24'd0, s});
        apb_write(REG_EXP_CMD, {24'd0, c});
        apb_write(REG_TIMEOUT, {16'd0, t});
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_resp w;
        if (i_rst_n && o_valid && i_ready) begin
            if (want_resp.size() == 0) begin
                $error("unexpected response: %p", o_resp);
                n_errors++;
            end else begin
                w = want_resp.pop_front();
                check_field("status", w.status, o_resp.status);
                check_field("data_byte", w.data_byte, o_resp.data_byte);
                check_field("byte_index", w.byte_index, o_resp.byte_index);
                check_field("payload_length", w.payload_length, o_resp.payload_length);
                check_field("last", w.last, o_resp.last);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (calm) begin
                i_ready <= 1'b1;
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = idle_len();
            end
        end
    end

    initial begin
        t_in_req r;
        int base;
        i_valid <= 1'b0;
        i_req   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        cfg_start   = START_BYTE_RST;
        cfg_cmd     = EXP_CMD_RST;
        cfg_timeout = TIMEOUT_RST;
        foreach (pay_store[i]) pay_store[i] = 8'd0;
        back_to_hunt();
        directed_tab = '{
            '{REQ_BYTE, 8'h00, 1'b1, ST_BAD_START},
            '{REQ_BYTE, 8'hFF, 1'b1, ST_BAD_START},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b1, ST_ZERO_LEN},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd34, 1'b1, ST_TOO_LONG},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd1,  1'b0, ST_OK},
            '{REQ_BYTE, 8'h80, 1'b1, ST_WRONG_CMD},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd1,  1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd233, 1'b1, ST_OK},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd1,  1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b1, ST_BAD_SUM},
            '{REQ_TICK, 8'hFF, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd22, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd3,  1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b0, ST_OK},
            '{REQ_BYTE, 8'hFF, 1'b0, ST_OK},
            '{REQ_TICK, 8'h00, 1'b0, ST_OK},
            '{REQ_BYTE, 8'h00, 1'b0, ST_OK},
            '{REQ_BYTE, 8'd232, 1'b0, ST_OK}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tab[k]) begin
            r.req_type = directed_tab[k].kind;
            r.rx_byte  = directed_tab[k].val;
            offer_req(r);
            if (directed_tab[k].typed) begin
                want_resp.push_back(resp(directed_tab[k].st, 8'd0, 5'd0, 6'd0, 1'b1));
            end else begin
                foreach (fresh_resp[j]) want_resp.push_back(fresh_resp[j]);
            end
        end
        base = sent_cnt;

        // stall the response side while full frames keep coming
        drain_results();
        program_regs(8'hA5, 8'h3C, 16'hFFFF);
        hold_req = 1'b1;
        repeat (4) send_frame(PAYLOAD_CAP, FL_NONE);
        run_until(base + RANDOM_ITEMS / 4);

        drain_results();
        apb_write(REG_UNUSED, $urandom);
        program_regs(8'h00, 8'hFF, 16'd1);
        calm = 1'b1;
        run_until(base + RANDOM_ITEMS * 3 / 8);
        calm = 1'b0;
        run_until(base + RANDOM_ITEMS / 2);

        drain_results();
        program_regs(8'hFF, 8'h00, 16'd40);
        run_until(base + RANDOM_ITEMS * 3 / 4);

        drain_results();
        program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(2, 300)));
        run_until(base + RANDOM_ITEMS);

        drain_results();
        if (n_errors == 0) begin
            $display("tb_sensor_frame_receiver passed");
        end else begin
            $display("tb_sensor_frame_receiver failed");
        end
        $finish;
    end

endmodule
